[hw/rtl/b64e_pkg.sv]
// Shared types, constants and the character table of the base64 stream encoder.
package b64e_pkg;

  // Width of the per-message character counter.
  localparam int unsigned CountBits = 16;
  // Width used for the capacity compare, wide enough for counter, capacity and carries.
  localparam int unsigned FitBits = ((CountBits > 16) ? CountBits : 16) + 2;
  localparam int unsigned CapBits = 16;
  localparam int unsigned CharBits = 8;
  localparam int unsigned TotalBits = 16;

  // Group queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  localparam logic [CapBits-1:0] CapResetValue = 16'hFFFF;
  localparam logic [CharBits-1:0] PadChar = 8'h3D;
  localparam logic [CharBits-1:0] OverflowChar = 8'h00;
  localparam logic [1:0] LowTwoMask = 2'h3;
  localparam logic [3:0] LowFourMask = 4'hF;
  localparam logic [5:0] SextetMask = 6'h3F;

  // Number of bytes in a group.
  localparam logic [1:0] OneByte = 2'd1;
  localparam logic [1:0] TwoBytes = 2'd2;
  localparam logic [1:0] ThreeBytes = 2'd3;

  // Character slots within a group.
  localparam logic [1:0] SlotFirst = 2'd0;
  localparam logic [1:0] SlotSecond = 2'd1;
  localparam logic [1:0] SlotThird = 2'd2;
  localparam logic [1:0] SlotFourth = 2'd3;

  localparam logic [7:0] Alphabet [64] = '{
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M", "N", "O", "P",
    "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z", "a", "b", "c", "d", "e", "f",
    "g", "h", "i", "j", "k", "l", "m", "n", "o", "p", "q", "r", "s", "t", "u", "v",
    "w", "x", "y", "z", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "+", "/"
  };

  // One complete group, or an overflow marker, handed from the front to the back.
  typedef struct packed {
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [7:0]           b2;
    logic [1:0]           nbytes;
    logic                 last;
    logic                 ovf;
    logic [CountBits-1:0] base;
  } job_t;

  function automatic logic [CharBits-1:0] b64_char(input logic [5:0] sextet);
    return Alphabet[sextet];
  endfunction

endpackage

[hw/rtl/b64e_in_if.sv]
// Byte input channel of the base64 stream encoder.
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/b64e_out_if.sv]
// Character output channel of the base64 stream encoder.
interface b64e_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        end_of_message;
  logic        status;
  logic [15:0] char_total;

  modport source (output valid, output out_char, output end_of_message, output status,
                  output char_total, input ready);
  modport sink (input valid, input out_char, input end_of_message, input status,
                input char_total, output ready);
endinterface

[hw/rtl/b64e_front.sv]
// Front end: gathers bytes into groups, checks capacity and queues groups.
module b64e_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [15:0]               cfg_wdata_i,
  b64e_in_if.sink                   in_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output b64e_pkg::job_t            job_o
);

  logic [b64e_pkg::CapBits-1:0]   cap_q;
  logic [7:0]                     held0_q, held0_d;
  logic [7:0]                     held1_q, held1_d;
  logic [1:0]                     phase_q, phase_d;
  logic [b64e_pkg::CountBits-1:0] count_q, count_d;
  logic                           drop_q, drop_d;

  logic                           accept;
  logic                           close;
  logic [b64e_pkg::FitBits-1:0]   need;
  logic [b64e_pkg::CountBits:0]   next4;
  logic                           ovf;

  assign in_i.ready = !q_full_i;
  assign accept = in_i.valid && in_i.ready;

  // Outside drop mode, a group closes on the third byte or on the last byte of the message.
  assign close = !drop_q && (in_i.last_byte || (phase_q == b64e_pkg::TwoBytes));

  assign need = b64e_pkg::FitBits'(count_q) + b64e_pkg::FitBits'(4)
              + b64e_pkg::FitBits'(in_i.last_byte);
  assign next4 = (b64e_pkg::CountBits + 1)'(count_q) + (b64e_pkg::CountBits + 1)'(4);
  assign ovf = (need > b64e_pkg::FitBits'(cap_q)) || next4[b64e_pkg::CountBits];

  always_comb begin
    job_o.base   = count_q;
    job_o.last   = in_i.last_byte;
    job_o.ovf    = ovf;
    job_o.nbytes = phase_q + 2'd1;
    case (phase_q)
      2'd0: begin
        job_o.b0 = in_i.data_byte;
        job_o.b1 = '0;
        job_o.b2 = '0;
      end
      2'd1: begin
        job_o.b0 = held0_q;
        job_o.b1 = in_i.data_byte;
        job_o.b2 = '0;
      end
      default: begin
        job_o.b0 = held0_q;
        job_o.b1 = held1_q;
        job_o.b2 = in_i.data_byte;
      end
    endcase
  end

  assign push_o = accept && close;

  always_comb begin
    held0_d = held0_q;
    held1_d = held1_q;
    phase_d = phase_q;
    count_d = count_q;
    drop_d  = drop_q;
    if (accept) begin
      if (drop_q) begin
        if (in_i.last_byte) begin
          drop_d  = 1'b0;
          held0_d = '0;
          held1_d = '0;
          phase_d = '0;
          count_d = '0;
        end
      end else if (!close) begin
        if (phase_q == 2'd0) begin
          held0_d = in_i.data_byte;
          phase_d = b64e_pkg::OneByte;
        end else begin
          held1_d = in_i.data_byte;
          phase_d = b64e_pkg::TwoBytes;
        end
      end else begin
        held0_d = '0;
        held1_d = '0;
        phase_d = '0;
        if (ovf || in_i.last_byte) begin
          count_d = '0;
        end else begin
          count_d = next4[b64e_pkg::CountBits-1:0];
        end
        if (ovf && !in_i.last_byte) begin
          drop_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= b64e_pkg::CapResetValue;
      held0_q <= '0;
      held1_q <= '0;
      phase_q <= '0;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      held0_q <= held0_d;
      held1_q <= held1_d;
      phase_q <= phase_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

`ifndef SYNTHESIS
  // A closed group never carries more bytes than a full group.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("group phase out of range");
`endif

endmodule

[hw/rtl/b64e_queue.sv]
// Short queue of closed groups between the front and the back.
module b64e_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output b64e_pkg::job_t pop_data_o
);

  b64e_pkg::job_t                    mem_q [b64e_pkg::QueueDepth];
  logic [b64e_pkg::QueuePtrBits-1:0] wptr_q, rptr_q;
  logic [b64e_pkg::QueueCntBits-1:0] cnt_q;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == b64e_pkg::QueueCntBits'(b64e_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign pop_data_o = mem_q[rptr_q];

  function automatic logic [b64e_pkg::QueuePtrBits-1:0] ptr_next(
    input logic [b64e_pkg::QueuePtrBits-1:0] p);
    if (p == b64e_pkg::QueuePtrBits'(b64e_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("group pushed into a full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= b64e_pkg::QueueCntBits'(b64e_pkg::QueueDepth))
    else $error("queue fill count beyond depth");
`endif

endmodule

[hw/rtl/b64e_back.sv]
// Back end: turns queued groups into character transactions, one per cycle while out_o is not stalled.
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  b64e_pkg::job_t q_data_i,
  output logic           pop_o,
  b64e_out_if.source     out_o
);

  b64e_pkg::job_t job_q;
  logic           busy_q;
  logic [1:0]     slot_q;

  logic                           ovalid_q;
  logic [7:0]                     ochar_q;
  logic                           oeom_q;
  logic                           ostatus_q;
  logic [15:0]                    ototal_q;

  logic                           can_load;
  logic                           emit;
  logic                           finish;
  logic [5:0]                     sextet;
  logic [7:0]                     chr;
  logic [b64e_pkg::CountBits-1:0] total;

  assign can_load = !ovalid_q || out_o.ready;
  assign emit     = busy_q && can_load;
  assign finish   = emit && (job_q.ovf || (slot_q == b64e_pkg::SlotFourth));
  assign pop_o    = q_valid_i && (!busy_q || finish);

  always_comb begin
    case (slot_q)
      b64e_pkg::SlotFirst:  sextet = job_q.b0[7:2];
      b64e_pkg::SlotSecond: sextet = {job_q.b0[1:0] & b64e_pkg::LowTwoMask, job_q.b1[7:4]};
      b64e_pkg::SlotThird:  sextet = {job_q.b1[3:0] & b64e_pkg::LowFourMask, job_q.b2[7:6]};
      default:              sextet = job_q.b2[5:0] & b64e_pkg::SextetMask;
    endcase
  end

  // The third slot pads a one-byte group, the fourth slot pads any short group.
  always_comb begin
    chr = b64e_pkg::b64_char(sextet);
    if (job_q.ovf) begin
      chr = b64e_pkg::OverflowChar;
    end else if ((slot_q == b64e_pkg::SlotThird) && (job_q.nbytes == b64e_pkg::OneByte)) begin
      chr = b64e_pkg::PadChar;
    end else if ((slot_q == b64e_pkg::SlotFourth) && (job_q.nbytes != b64e_pkg::ThreeBytes))
    begin
      chr = b64e_pkg::PadChar;
    end
  end

  assign total = job_q.ovf ? job_q.base
               : job_q.base + b64e_pkg::CountBits'(slot_q) + b64e_pkg::CountBits'(1);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_data_i;
    end
    if (emit) begin
      ochar_q   <= chr;
      oeom_q    <= job_q.ovf || (job_q.last && (slot_q == b64e_pkg::SlotFourth));
      ostatus_q <= job_q.ovf;
      ototal_q  <= b64e_pkg::TotalBits'(total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      slot_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        slot_q <= '0;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        slot_q <= slot_q + 2'd1;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.out_char       = ochar_q;
  assign out_o.end_of_message = oeom_q;
  assign out_o.status         = ostatus_q;
  assign out_o.char_total     = ototal_q;

`ifndef SYNTHESIS
  // An overflow transaction always closes its message.
  a_ovf_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostatus_q) |-> oeom_q) else $error("overflow without end of message");
  // Only an idle back end or one finishing its group may take a new group.
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!busy_q || finish)) else $error("group taken while busy");
`endif

endmodule

[hw/rtl/base64_stream_encoder_unit.sv]
// Top level of the base64 stream encoder.
//
// in_i carries one message byte per transaction, with last_byte set on the final
// byte. out_o carries one character per transaction: base64 characters, '=' pad,
// or a single overflow transaction (status set, end_of_message set). char_total
// counts the characters of the current message, the shown one included but for overflow.
// The user must write the capacity register through cfg_we_i / cfg_wdata_i only while idle;
// the block does not enforce it. A closing byte passes the group queue, the back end's group
// register and the output register to out_o; its characters follow one per cycle unless stalled.
// The back end emits one character per cycle while out_o is not stalled, which limits
// sustained input for full groups to three bytes per four characters; bytes that do not close a group
// are accepted back to back while the group queue has room.
// A two-entry group queue separates byte intake from character output, so intake
// continues while out_o is stalled until that queue fills, then in_i.ready drops.
// Reset clears the pending bytes, the counter, drop mode and the queue and sets
// the capacity to 65535; no transaction is pending on out_o after reset.
module base64_stream_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  b64e_in_if.sink     in_i,
  b64e_out_if.source  out_o
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  b64e_pkg::job_t push_job;
  b64e_pkg::job_t pop_job;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  b64e_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (pop_job),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the base64 stream encoder: directed table, then random messages.
module tb;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles = 100;
  localparam int unsigned HoldAfterBytes = 30;
  localparam int unsigned PhaseBytes = 16;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eom;
    logic        st;
    logic [15:0] total;
  } char_rec_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_CHARS, ROW_OVERFLOW, ROW_SET_CAP} row_kind_e;

  // For ROW_CHARS, val is the count before the group; for ROW_OVERFLOW, the reported total;
  // for ROW_SET_CAP, the new capacity.
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] chars;
    logic [15:0] val;
  } stim_row_t;

  localparam int unsigned DirRows = 27;
  stim_row_t dir_tab [DirRows] = '{
    '{ROW_CHARS,    8'h00, 1'b1, "AA==", 16'd0},
    '{ROW_CHARS,    8'hFF, 1'b1, "/w==", 16'd0},
    '{ROW_PREDICT,  8'hFF, 1'b0, "    ", 16'd0},
    '{ROW_CHARS,    8'hFF, 1'b1, "//8=", 16'd0},
    '{ROW_PREDICT,  8'h00, 1'b0, "    ", 16'd0},
    '{ROW_PREDICT,  8'h00, 1'b0, "    ", 16'd0},
    '{ROW_CHARS,    8'h00, 1'b1, "AAAA", 16'd0},
    '{ROW_PREDICT,  8'hFF, 1'b0, "    ", 16'd0},
    '{ROW_PREDICT,  8'hFF, 1'b0, "    ", 16'd0},
    '{ROW_CHARS,    8'hFF, 1'b0, "////", 16'd0},
    '{ROW_PREDICT,  8'h00, 1'b1, "    ", 16'd0},
    '{ROW_PREDICT,  8'h4D, 1'b0, "    ", 16'd0},
    '{ROW_PREDICT,  8'h61, 1'b0, "    ", 16'd0},
    '{ROW_CHARS,    8'h6E, 1'b1, "TWFu", 16'd0},
    '{ROW_SET_CAP,  8'h00, 1'b0, "    ", 16'd4},
    '{ROW_OVERFLOW, 8'h55, 1'b1, "    ", 16'd0},
    '{ROW_PREDICT,  8'h01, 1'b0, "    ", 16'd0},
    '{ROW_PREDICT,  8'h02, 1'b0, "    ", 16'd0},
    '{ROW_PREDICT,  8'h03, 1'b0, "    ", 16'd0},
    '{ROW_PREDICT,  8'h04, 1'b0, "    ", 16'd0},
    '{ROW_PREDICT,  8'h05, 1'b0, "    ", 16'd0},
    '{ROW_OVERFLOW, 8'h06, 1'b0, "    ", 16'd4},
    '{ROW_PREDICT,  8'h07, 1'b1, "    ", 16'd0},
    '{ROW_SET_CAP,  8'h00, 1'b0, "    ", 16'd0},
    '{ROW_OVERFLOW, 8'h12, 1'b1, "    ", 16'd0},
    '{ROW_SET_CAP,  8'h00, 1'b0, "    ", 16'd5},
    '{ROW_CHARS,    8'h80, 1'b1, "gA==", 16'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  b64e_in_if  in_if ();
  b64e_out_if out_if ();

  base64_stream_encoder_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor state.
  logic [15:0] cap_reg;
  logic [15:0] pend_bytes;
  logic [1:0]  pend_cnt;
  logic [15:0] msg_chars;
  logic        skip_rest;
  char_rec_t   grp_out [4];

  char_rec_t   char_q [$];

  int unsigned err_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned ovf_cnt = 0;
  int unsigned bytes_sent;
  int unsigned cap_writes;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    else if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  // Advances the encoder state by one byte and leaves its characters in grp_out.
  function automatic int encode_byte(input logic [7:0] b, input logic l);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [1:0]  n;
    logic [16:0] need;
    logic [7:0]  c [4];
    b1 = 8'h00;
    b2 = 8'h00;
    if (skip_rest) begin
      if (l) begin
        skip_rest = 1'b0;
        pend_bytes = '0;
        pend_cnt = '0;
        msg_chars = '0;
      end
      return 0;
    end
    if (!l && pend_cnt == 2'd0) begin
      pend_bytes = {b, 8'h00};
      pend_cnt = 2'd1;
      return 0;
    end
    if (!l && pend_cnt == 2'd1) begin
      pend_bytes[7:0] = b;
      pend_cnt = 2'd2;
      return 0;
    end
    case (pend_cnt)
      2'd0: begin
        n = b64e_pkg::OneByte;
        b0 = b;
      end
      2'd1: begin
        n = b64e_pkg::TwoBytes;
        b0 = pend_bytes[15:8];
        b1 = b;
      end
      default: begin
        n = b64e_pkg::ThreeBytes;
        b0 = pend_bytes[15:8];
        b1 = pend_bytes[7:0];
        b2 = b;
      end
    endcase
    // The group on the last byte must also leave room for one more character.
    need = {1'b0, msg_chars} + 17'd4 + {16'd0, l};
    if (need > {1'b0, cap_reg} || {1'b0, msg_chars} + 17'd4 > 17'h0FFFF) begin
      grp_out[0] = '{b64e_pkg::OverflowChar, 1'b1, 1'b1, msg_chars};
      pend_bytes = '0;
      pend_cnt = '0;
      msg_chars = '0;
      if (!l) skip_rest = 1'b1;
      return 1;
    end
    c[0] = sextet_char(b0[7:2]);
    c[1] = sextet_char({b0[1:0], b1[7:4]});
    c[2] = (n >= b64e_pkg::TwoBytes) ? sextet_char({b1[3:0], b2[7:6]}) : b64e_pkg::PadChar;
    c[3] = (n == b64e_pkg::ThreeBytes) ? sextet_char(b2[5:0]) : b64e_pkg::PadChar;
    for (int k = 0; k < 4; k++) begin
      grp_out[k] = '{c[k], l && (k == 3), 1'b0, msg_chars + 16'(k + 1)};
    end
    pend_bytes = '0;
    pend_cnt = '0;
    msg_chars = msg_chars + 16'd4;
    if (l) msg_chars = '0;
    return 4;
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l);
    while (!calm && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic issue_byte(input logic [7:0] d, input logic l);
    int n;
    n = encode_byte(d, l);
    for (int i = 0; i < n; i++) char_q.push_back(grp_out[i]);
    send_byte(d, l);
  endtask

  // Stops offering bytes until every expected character has arrived, then lets the
  // block settle for the given number of cycles.
  task automatic drain_results(input int unsigned extra);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (char_q.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
    cap_writes++;
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk_i) begin
    char_rec_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        res_cnt++;
        if (out_if.status) ovf_cnt++;
        if (char_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected transaction: char %h eom %b status %b total %0d",
                     out_if.out_char, out_if.end_of_message, out_if.status,
                     out_if.char_total);
          end
        end else begin
          want = char_q.pop_front();
          if (want.ch !== out_if.out_char || want.eom !== out_if.end_of_message ||
              want.st !== out_if.status || want.total !== out_if.char_total) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: expected char %h eom %b status %b total %0d",
                       want.ch, want.eom, want.st, want.total);
              $display("          actual   char %h eom %b status %b total %0d",
                       out_if.out_char, out_if.end_of_message, out_if.status,
                       out_if.char_total);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (!hold_done && bytes_sent >= HoldAfterBytes) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned msg_len;
    int unsigned phase_bytes;
    logic [15:0] cap_val;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cap_reg = b64e_pkg::CapResetValue;
    pend_bytes = '0;
    pend_cnt = '0;
    msg_chars = '0;
    skip_rest = 1'b0;
    bytes_sent = 0;
    cap_writes = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      if (dir_tab[r].kind == ROW_SET_CAP) begin
        drain_results(SettleCycles);
        write_capacity(dir_tab[r].val);
      end else if (dir_tab[r].kind == ROW_PREDICT) begin
        issue_byte(dir_tab[r].data, dir_tab[r].last);
      end else begin
        // The predictor still has to track the state of typed rows.
        void'(encode_byte(dir_tab[r].data, dir_tab[r].last));
        if (dir_tab[r].kind == ROW_CHARS) begin
          for (int k = 0; k < 4; k++) begin
            char_q.push_back('{dir_tab[r].chars[31 - 8 * k -: 8], dir_tab[r].last && (k == 3),
                               1'b0, dir_tab[r].val + 16'(k + 1)});
          end
        end else begin
          char_q.push_back('{b64e_pkg::OverflowChar, 1'b1, 1'b1, dir_tab[r].val});
        end
        send_byte(dir_tab[r].data, dir_tab[r].last);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cap_val = 16'hFFFF;
        1: cap_val = 16'($urandom_range(40, 8));
        2: cap_val = 16'($urandom_range(20, 0));
        3: cap_val = 16'($urandom);
        4: cap_val = 16'($urandom_range(16, 4));
        default: cap_val = 16'hFFFE;
      endcase
      drain_results(SettleCycles);
      write_capacity(cap_val);
      calm <= (ph == 1);
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        msg_len = ($urandom_range(7) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
        for (int i = 0; i < msg_len; i++) begin
          // Pause on the sender side, possibly mid-message, until the output has caught up.
          if (ph == 3 && phase_bytes == 12) drain_results(0);
          issue_byte(8'($urandom_range(255)), i == msg_len - 1);
          phase_bytes++;
        end
      end
    end

    calm <= 1'b0;
    drain_results(SettleCycles + 4);
    $display("Run covered %0d bytes in, %0d characters checked, %0d overflow transactions,",
             bytes_sent, res_cnt, ovf_cnt);
    $display("  over %0d capacity settings including 0, 4, 5 and the full range.", cap_writes);
    if (err_cnt == 0 && char_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("errors: %0d, expectations left: %0d", err_cnt, char_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_in_if.sv
hw/rtl/b64e_out_if.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder_unit.sv
tb/tb.sv
